// ===== hdl/sbcd_pkg.sv =====
// ---------------------------------------------------------------------------
// sbcd_pkg - shared types and constants for the seconds-to-BCD display core
// Holds the pipeline payload struct, the place codes and the weight table
// used by each digit stage.
// ---------------------------------------------------------------------------
`default_nettype none

package sbcd_pkg;

    localparam int unsigned DIGIT_W    = 4;
    localparam int unsigned NUM_PLACES = 5;
    localparam int unsigned REM_W      = 19;     // holds any count below 360000
    localparam int unsigned IN_W       = 32;
    localparam int unsigned LOW_W      = 16;
    localparam int unsigned HIGH_W     = 12;
    localparam int unsigned OUT_DATA_W = 56;     // 52 payload bits padded to bytes

    localparam int unsigned SAT_LIMIT  = 360000;

    localparam logic [DIGIT_W-1:0] BLANK_DIGIT = 4'd15;
    localparam logic [DIGIT_W-1:0] SAT_DIGIT   = 4'd9;
    localparam logic [LOW_W-1:0]   BLANK_LOW   = 16'hffff;
    localparam logic [HIGH_W-1:0]  BLANK_HIGH  = 12'h fff;

    // Place codes: position of a digit in the digit vector
    localparam logic [2:0] PLACE_HOURS_TENS   = 3'd0;
    localparam logic [2:0] PLACE_HOURS_ONES   = 3'd1;
    localparam logic [2:0] PLACE_MINUTES_TENS = 3'd2;
    localparam logic [2:0] PLACE_MINUTES_ONES = 3'd3;
    localparam logic [2:0] PLACE_SECS_TENS    = 3'd4;

    typedef struct packed {
        logic                                  blank;
        logic                                  sat;
        logic [REM_W-1:0]                      rem;
        logic [NUM_PLACES-1:0][DIGIT_W-1:0]    digits;
    } stage_t;

    // k times the weight of a place; weights are 36000, 3600, 600, 60, 10
    function automatic logic [REM_W-1:0] place_multiple(input logic [2:0] place,
                                                        input logic [DIGIT_W-1:0] k);
        logic [REM_W-1:0] w;
        logic [REM_W+DIGIT_W-1:0] prod;
        unique case (place)
            PLACE_HOURS_TENS:   w = REM_W'(36000);
            PLACE_HOURS_ONES:   w = REM_W'(3600);
            PLACE_MINUTES_TENS: w = REM_W'(600);
            PLACE_MINUTES_ONES: w = REM_W'(60);
            PLACE_SECS_TENS:    w = REM_W'(10);
            default:            w = '0;
        endcase
        prod = {{DIGIT_W{1'b0}}, w} * {{REM_W{1'b0}}, k};
        return prod[REM_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sbcd_digit.sv =====
// ---------------------------------------------------------------------------
// sbcd_digit - one pipeline stage that extracts a single BCD digit
// Compares the remainder against all nine multiples of the place weight in
// parallel, registers the digit and the reduced remainder.
// ---------------------------------------------------------------------------
`default_nettype none

module sbcd_digit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [2:0]          place,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire sbcd_pkg::stage_t    in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output sbcd_pkg::stage_t         out_data
);

    logic                              valid_reg;
    sbcd_pkg::stage_t                  data_reg;
    sbcd_pkg::stage_t                  data_next;
    logic [sbcd_pkg::DIGIT_W-1:0]      digit;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Remainder is always below ten times the weight, so the digit is the
    // largest multiple that fits; the compares are monotonic in k.
    always_comb
    begin
        digit = '0;
        for (int k = 1; k <= 9; k++)
        begin
            if (in_data.rem >= sbcd_pkg::place_multiple(place, sbcd_pkg::DIGIT_W'(k)))
            begin
                digit = sbcd_pkg::DIGIT_W'(k);
            end
        end
        data_next               = in_data;
        data_next.digits[place] = digit;
        data_next.rem           = in_data.rem - sbcd_pkg::place_multiple(place, digit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/seconds_to_bcd_clock_display_core.sv =====
// ---------------------------------------------------------------------------
// seconds_to_bcd_clock_display_core - signed seconds to HH:MM:SS BCD digits
// Seven-stage pipeline: classify, five digit stages, output pack register.
// ---------------------------------------------------------------------------
// Takes one signed count of seconds per transaction and returns six BCD
// digits plus two packed display words. A count of zero or less blanks the
// display (all digits 15, words 0xffff / 0x0fff, tuser high); a count of
// 360000 or more shows 99:99:99. The pipeline accepts one transaction per
// cycle while it is not stalled; each result passes through the classify
// register, the five digit stages and the output register in turn. The
// depth is set by the seven registers in the path: classify, one per digit
// stage and the output register. Each stage has its own valid bit and
// ready, so bubbles collapse and a stalled output only holds the input
// once every stage is full.
`default_nettype none

module seconds_to_bcd_clock_display_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [sbcd_pkg::IN_W-1:0]       s_axis_tdata,  // [31:0] elapsed_seconds
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [sbcd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // [3:0] hours_tens_digit,
                                                                // [7:4] hours_ones_digit,
                                                                // [11:8] minutes_tens_digit,
                                                                // [15:12] minutes_ones_digit,
                                                                // [19:16] secs_tens_digit,
                                                                // [23:20] secs_ones_digit,
                                                                // [39:24] low_port_word,
                                                                // [51:40] high_port_word,
                                                                // [55:52] zero
    output logic                                 m_axis_tuser   // [0] blanked
);

    localparam int unsigned NP = sbcd_pkg::NUM_PLACES;

    // Classify stage
    logic                  cls_valid_reg;
    sbcd_pkg::stage_t      cls_data_reg;
    sbcd_pkg::stage_t      cls_data_next;
    logic                  cls_ready;
    logic                  in_blank;
    logic                  in_sat;

    // Digit stage links: index 0 is the classify stage output
    logic [NP:0]           link_valid;
    logic [NP:0]           link_ready;
    sbcd_pkg::stage_t      link_data [NP+1];

    // Output stage
    logic                                out_valid_reg;
    logic [sbcd_pkg::OUT_DATA_W-1:0]     out_data_reg;
    logic [sbcd_pkg::OUT_DATA_W-1:0]     out_data_next;
    logic                                out_blank_reg;
    logic                                out_ready;

    logic [sbcd_pkg::DIGIT_W-1:0] d_ht, d_ho, d_mt, d_mo, d_st, d_so;
    logic [sbcd_pkg::LOW_W-1:0]   low_word;
    logic [sbcd_pkg::HIGH_W-1:0]  high_word;
    sbcd_pkg::stage_t             last;

    // ---------------- classify ----------------
    assign cls_ready     = !cls_valid_reg || link_ready[0];
    assign s_axis_tready = cls_ready;

    always_comb
    begin
        in_blank = (s_axis_tdata == 32'd0) || s_axis_tdata[31];
        in_sat   = !in_blank && (s_axis_tdata[30:0] >= 31'(sbcd_pkg::SAT_LIMIT));
        cls_data_next        = '0;
        cls_data_next.blank  = in_blank;
        cls_data_next.sat    = in_sat;
        cls_data_next.rem    = (in_blank || in_sat) ? '0
                                                    : s_axis_tdata[sbcd_pkg::REM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_valid_reg <= 1'b0;
        end
        else if (cls_ready)
        begin
            cls_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cls_ready && s_axis_tvalid)
        begin
            cls_data_reg <= cls_data_next;
        end
    end

    assign link_valid[0] = cls_valid_reg;
    assign link_data[0]  = cls_data_reg;

    // ---------------- digit stages ----------------
    for (genvar g = 0; g < NP; g++)
    begin : g_digit
        sbcd_digit u_digit (
            .clk       (clk),
            .rst_n     (rst_n),
            .place     (3'(g)),
            .in_valid  (link_valid[g]),
            .in_ready  (link_ready[g]),
            .in_data   (link_data[g]),
            .out_valid (link_valid[g+1]),
            .out_ready (link_ready[g+1]),
            .out_data  (link_data[g+1])
        );
    end

    // ---------------- output pack ----------------
    assign out_ready      = !out_valid_reg || m_axis_tready;
    assign link_ready[NP] = out_ready;
    assign last           = link_data[NP];

    always_comb
    begin
        if (last.blank)
        begin
            d_ht = sbcd_pkg::BLANK_DIGIT;
            d_ho = sbcd_pkg::BLANK_DIGIT;
            d_mt = sbcd_pkg::BLANK_DIGIT;
            d_mo = sbcd_pkg::BLANK_DIGIT;
            d_st = sbcd_pkg::BLANK_DIGIT;
            d_so = sbcd_pkg::BLANK_DIGIT;
        end
        else if (last.sat)
        begin
            d_ht = sbcd_pkg::SAT_DIGIT;
            d_ho = sbcd_pkg::SAT_DIGIT;
            d_mt = sbcd_pkg::SAT_DIGIT;
            d_mo = sbcd_pkg::SAT_DIGIT;
            d_st = sbcd_pkg::SAT_DIGIT;
            d_so = sbcd_pkg::SAT_DIGIT;
        end
        else
        begin
            d_ht = last.digits[sbcd_pkg::PLACE_HOURS_TENS];
            d_ho = last.digits[sbcd_pkg::PLACE_HOURS_ONES];
            d_mt = last.digits[sbcd_pkg::PLACE_MINUTES_TENS];
            d_mo = last.digits[sbcd_pkg::PLACE_MINUTES_ONES];
            d_st = last.digits[sbcd_pkg::PLACE_SECS_TENS];
            d_so = last.rem[sbcd_pkg::DIGIT_W-1:0];
        end

        if (last.blank)
        begin
            low_word  = sbcd_pkg::BLANK_LOW;
            high_word = sbcd_pkg::BLANK_HIGH;
        end
        else
        begin
            low_word  = {d_mo, d_st, d_so, 4'd0};
            high_word = {d_ht, d_ho, d_mt};
        end

        out_data_next = {4'd0, high_word, low_word, d_so, d_st, d_mo, d_mt, d_ho, d_ht};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= link_valid[NP];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && link_valid[NP])
        begin
            out_data_reg  <= out_data_next;
            out_blank_reg <= last.blank;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_blank_reg;

    // ---------------- assertions ----------------
    a_blank_digits: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[23:0] == 24'hffffff)
        else $error("blanked result with non-blank digits");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tdata[3:0] <= 4'd9 && m_axis_tdata[7:4] <= 4'd9 &&
            m_axis_tdata[11:8] <= 4'd9 && m_axis_tdata[15:12] <= 4'd9 &&
            m_axis_tdata[19:16] <= 4'd9 && m_axis_tdata[23:20] <= 4'd9)
        else $error("digit out of BCD range");

    a_low_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tdata[39:24] == {m_axis_tdata[15:12], m_axis_tdata[19:16],
                                    m_axis_tdata[23:20], 4'd0})
        else $error("low port word does not match digits");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while output is free");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[55:52] == 4'd0)
        else $error("padding bits not zero");

endmodule

`default_nettype wire
